>>> rtl/count_multiples_of_any_divisor_top_assert.svh
// Assertion macros for the multiples-count block.
// Used by the divider, the sequencer and the top level; no other dependency.
`ifndef COUNT_MULTIPLES_OF_ANY_DIVISOR_TOP_ASSERT_SVH
`define COUNT_MULTIPLES_OF_ANY_DIVISOR_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define CMD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define CMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cmd_pkg.sv
// Package for the multiples-count block: widths, payload structs, state enum.
// No dependencies.
`timescale 1ns / 1ps

package cmd_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int DIV_CNT_W     = $clog2(OPERAND_WIDTH + 1);

    typedef struct packed {
        logic [31:0] upper_limit;
        logic [31:0] divisor_one;
        logic [31:0] divisor_two;
        logic [31:0] divisor_three;
        logic [31:0] divisor_four;
    } cmd_in_t;

    typedef struct packed {
        logic [31:0] multiple_count;
        logic        divisor_error;
    } cmd_out_t;

    // Divider handshake toward the sequencer
    typedef struct packed {
        logic done;
        logic busy;
    } cmd_div_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUBSET,     // pick next subset / member
        ST_GCD_DIV,    // wait for x % y
        ST_Q_START,    // start acc / g
        ST_Q_DIV,
        ST_LY_DIV,     // wait for lim / y
        ST_MUL,        // q * y with bound check
        ST_TERM_START,
        ST_TERM_DIV,   // wait for lim / acc
        ST_DONE
    } cmd_state_t;

endpackage

>>> rtl/cmd_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on cmd_pkg and the assertion header.
`timescale 1ns / 1ps
`include "count_multiples_of_any_divisor_top_assert.svh"

module cmd_divider
    import cmd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     go,
    input  logic [OPERAND_WIDTH-1:0] dividend,
    input  logic [OPERAND_WIDTH-1:0] divisor,
    output logic [OPERAND_WIDTH-1:0] quotient,
    output logic [OPERAND_WIDTH-1:0] remainder,
    output cmd_div_stat_t            stat
);

    logic [OPERAND_WIDTH-1:0] quo_reg, quo_next;
    logic [OPERAND_WIDTH-1:0] rem_reg, rem_next;
    logic [OPERAND_WIDTH-1:0] dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [OPERAND_WIDTH:0]   trial;

    // Load the operands on go, else one shift-subtract step while busy
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[OPERAND_WIDTH-1]} - {1'b0, dvs_reg};
        if (go)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(OPERAND_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[OPERAND_WIDTH])
            begin
                rem_next = trial[OPERAND_WIDTH-1:0];
                quo_next = {quo_reg[OPERAND_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[OPERAND_WIDTH-2:0], quo_reg[OPERAND_WIDTH-1]};
                quo_next = {quo_reg[OPERAND_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat      = '{done: done_reg, busy: busy_reg};

    `CMD_ASSERT_NEXT(a_div_done_after_last, busy_reg && cnt_reg == DIV_CNT_W'(1) && !go,
        done_reg, "divider missed done")
    `CMD_ASSERT_IMP(a_div_done_not_busy, done_reg, !busy_reg, "done while busy")
    `CMD_ASSERT_IMP(a_div_cnt_range, busy_reg, cnt_reg != '0, "busy with zero count")

endmodule

>>> rtl/cmd_sequencer.sv
// Sequencer: walks the fifteen subsets, runs gcd/lcm and terms on the divider.
// Depends on cmd_pkg, cmd_divider and the assertion header.
`timescale 1ns / 1ps
`include "count_multiples_of_any_divisor_top_assert.svh"

module cmd_sequencer
    import cmd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     go,
    input  cmd_in_t  item,
    output logic     idle,
    output logic     fin,
    output cmd_out_t res
);

    localparam int W = OPERAND_WIDTH;

    cmd_state_t state_reg, state_next;

    logic [W-1:0] lim_reg, lim_next;
    logic [W-1:0] dv_reg [4];
    logic [W-1:0] dv_next [4];
    logic [3:0]   sub_reg, sub_next;
    logic [1:0]   k_reg, k_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] gx_reg, gx_next;
    logic [W-1:0] gy_reg, gy_next;
    logic [W-1:0] q_reg, q_next;
    logic         bey_reg, bey_next;
    logic         par_reg, par_next;
    logic [W-1:0] tot_reg, tot_next;
    logic         err_reg, err_next;

    logic         dgo;
    logic [W-1:0] dnum, dden, dquo, drem;
    cmd_div_stat_t dstat;
    logic [2*W-1:0] prod;
    logic [W-1:0]   cur_dv;

    cmd_divider u_div (
        .clk(clk), .rst_n(rst_n), .go(dgo), .dividend(dnum), .divisor(dden),
        .quotient(dquo), .remainder(drem), .stat(dstat)
    );

    assign cur_dv = dv_reg[k_reg];
    assign prod   = q_reg * cur_dv;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (go) state_next = ST_SUBSET;
            ST_SUBSET:
                if (err_reg || sub_reg == 4'd0) state_next = ST_DONE;
                else if (bey_reg) state_next = ST_SUBSET;
                else if (sub_reg[k_reg])
                    state_next = (gy_reg == '0) ? ST_Q_START : ST_GCD_DIV;
                else if (k_reg == 2'd3) state_next = ST_TERM_START;
            ST_GCD_DIV:
                if (dstat.done) state_next = (drem == '0) ? ST_Q_START : ST_GCD_DIV;
            ST_Q_START:   state_next = ST_Q_DIV;
            ST_Q_DIV:     if (dstat.done) state_next = ST_LY_DIV;
            ST_LY_DIV:    if (dstat.done) state_next = ST_MUL;
            ST_MUL:
                state_next = (bey_next || k_reg == 2'd3) ? ST_TERM_START : ST_SUBSET;
            ST_TERM_START: state_next = ST_TERM_DIV;
            // saturated subset has no divide to wait for
            ST_TERM_DIV:  if (dstat.done || bey_reg) state_next = ST_SUBSET;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and divider control
    always_comb
    begin
        lim_next = lim_reg;
        dv_next  = dv_reg;
        sub_next = sub_reg;
        k_next   = k_reg;
        acc_next = acc_reg;
        gx_next  = gx_reg;
        gy_next  = gy_reg;
        q_next   = q_reg;
        bey_next = bey_reg;
        par_next = par_reg;
        tot_next = tot_reg;
        err_next = err_reg;
        dgo  = 1'b0;
        dnum = gx_reg;
        dden = gy_reg;
        case (state_reg)
            ST_IDLE:
                if (go)
                begin
                    lim_next   = W'(item.upper_limit);
                    dv_next[0] = W'(item.divisor_one);
                    dv_next[1] = W'(item.divisor_two);
                    dv_next[2] = W'(item.divisor_three);
                    dv_next[3] = W'(item.divisor_four);
                    err_next   = (W'(item.divisor_one) == '0) || (W'(item.divisor_two) == '0)
                              || (W'(item.divisor_three) == '0)
                              || (W'(item.divisor_four) == '0);
                    sub_next = 4'd1;
                    k_next   = 2'd0;
                    acc_next = W'(1);
                    bey_next = 1'b0;
                    par_next = 1'b0;
                    tot_next = '0;
                    gy_next  = '1;
                end
            ST_SUBSET:
                if (!err_reg && sub_reg != 4'd0)
                begin
                    if (bey_reg)
                    begin
                        // subset dropped: move on
                        sub_next = sub_reg + 4'd1;
                        k_next   = 2'd0;
                        acc_next = W'(1);
                        bey_next = 1'b0;
                        par_next = 1'b0;
                    end
                    else if (sub_reg[k_reg])
                    begin
                        par_next = ~par_reg;
                        gx_next  = acc_reg;
                        gy_next  = cur_dv;
                        dgo      = 1'b1;
                        dnum     = acc_reg;
                        dden     = cur_dv;
                    end
                    else if (k_reg != 2'd3)
                        k_next = k_reg + 2'd1;
                end
            ST_GCD_DIV:
                if (dstat.done)
                begin
                    gx_next = gy_reg;
                    gy_next = drem;
                    if (drem != '0)
                    begin
                        dgo  = 1'b1;
                        dnum = gy_reg;
                        dden = drem;
                    end
                end
            ST_Q_START:
            begin
                dgo  = 1'b1;
                dnum = acc_reg;
                dden = gx_reg;
            end
            ST_Q_DIV:
                if (dstat.done)
                begin
                    q_next = dquo;
                    dgo    = 1'b1;
                    dnum   = lim_reg;
                    dden   = cur_dv;
                end
            ST_LY_DIV:
                if (dstat.done) gx_next = dquo;
            ST_MUL:
            begin
                if (q_reg > gx_reg) bey_next = 1'b1;
                else acc_next = prod[W-1:0];
                gy_next = '1;
                if (k_reg != 2'd3) k_next = k_reg + 2'd1;
            end
            ST_TERM_START:
                if (!bey_reg)
                begin
                    dgo  = 1'b1;
                    dnum = lim_reg;
                    dden = acc_reg;
                end
            ST_TERM_DIV:
                if (dstat.done || bey_reg)
                begin
                    if (!bey_reg)
                        tot_next = par_reg ? tot_reg + dquo : tot_reg - dquo;
                    sub_next = sub_reg + 4'd1;
                    k_next   = 2'd0;
                    acc_next = W'(1);
                    bey_next = 1'b0;
                    par_next = 1'b0;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_IDLE;
        else        state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        lim_reg <= lim_next;
        dv_reg  <= dv_next;
        sub_reg <= sub_next;
        k_reg   <= k_next;
        acc_reg <= acc_next;
        gx_reg  <= gx_next;
        gy_reg  <= gy_next;
        q_reg   <= q_next;
        bey_reg <= bey_next;
        par_reg <= par_next;
        tot_reg <= tot_next;
        err_reg <= err_next;
    end

    // Outputs
    always_comb
    begin
        idle = (state_reg == ST_IDLE);
        fin  = (state_reg == ST_DONE);
        res.multiple_count = err_reg ? 32'd0 : 32'(tot_reg);
        res.divisor_error  = err_reg;
    end

    `CMD_ASSERT_IMP(a_seq_div_free, dgo, !dstat.busy, "divider started while busy")
    `CMD_ASSERT_NEXT(a_seq_fin_idle, fin, idle, "no return to idle after result")
    `CMD_ASSERT_IMP(a_seq_err_zero, fin && res.divisor_error,
        res.multiple_count == 32'd0, "error with nonzero count")

endmodule

>>> rtl/count_multiples_of_any_divisor_top.sv
// Channel  | Ports                  | Transfer
// in       | start, busy, in_item   | start && !busy at a rising edge
// out      | done, out_item         | done high for one cycle, no stall
// All divides run on the one radix-2 divider. For each subset member the sequencer
// runs gcd steps of x % y starting from acc and y, then the acc/g and lim/y divides
// and a bound-checked multiply; each subset term adds a lim/acc divide unless its lcm saturated.
// Zero divisor: the sequencer goes from its subset state straight to done.
// Reset clears the sequencer to idle; busy is low after reset.
// The receiver cannot stall; done pulses once per item.
// Depends on cmd_pkg, cmd_sequencer and the assertion header.
`timescale 1ns / 1ps
`include "count_multiples_of_any_divisor_top_assert.svh"

module count_multiples_of_any_divisor_top
    import cmd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  cmd_in_t  in_item,
    output logic     done,
    output cmd_out_t out_item
);

    logic     idle;
    logic     fin;
    cmd_out_t res;

    cmd_sequencer u_seq (
        .clk(clk), .rst_n(rst_n), .go(start && idle), .item(in_item),
        .idle(idle), .fin(fin), .res(res)
    );

    assign busy     = !idle;
    assign done     = fin;
    assign out_item = res;

    `CMD_ASSERT_NEXT(a_top_busy_after_start, start && !busy, busy, "not busy after start")
    `CMD_ASSERT_IMP(a_top_done_busy, done, busy, "done while idle")
    `CMD_ASSERT_NEXT(a_top_done_pulse, done, !done, "done held over two cycles")

endmodule
